// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the radio text command interpreter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i while the block is out of reset.
`define RTCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define RTCI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/rtci_pkg.sv =====
// Package with the constants, character codes and command codes of the interpreter.
package rtci_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int LEN_W      = $clog2(LINE_DEPTH);

  localparam int FREQ_W    = 30;
  localparam int ID_W      = 14;
  localparam int RIT_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 30;
  localparam int BCD_W     = 40;
  localparam int CONV_CNT_W = $clog2(FREQ_W);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIO_ID = 2'd2;

  localparam logic [FREQ_W-1:0] FREQ_MIN_RST = 30'd30000;
  localparam logic [FREQ_W-1:0] FREQ_MAX_RST = 30'd470000000;
  localparam logic [ID_W-1:0]   RADIO_ID_RST = 14'd670;
  localparam logic [ID_W-1:0]   ID_TOP       = 14'd9999;

  localparam logic [FREQ_W-1:0] FREQ_TOP     = 30'd999999999;
  localparam logic [33:0]       FREQ_SAT     = 34'd1000000000;
  localparam logic [33:0]       LENIENT_SAT  = 34'd100000;

  localparam logic signed [RIT_W-1:0] RIT_LIMIT = 15'sd9999;
  localparam logic signed [RIT_W:0]   RIT_STEP  = 16'sd10;
  localparam logic [13:0]             RIT_MAG_TOP = 14'd9999;

  localparam logic [7:0] GAIN_TOP = 8'd255;
  localparam logic [7:0] SQL_TOP  = 8'd100;

  // Characters.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Two-letter command codes.
  localparam logic [15:0] CMD_FA = "FA";
  localparam logic [15:0] CMD_FB = "FB";
  localparam logic [15:0] CMD_IF = "IF";
  localparam logic [15:0] CMD_ID = "ID";
  localparam logic [15:0] CMD_MD = "MD";
  localparam logic [15:0] CMD_PS = "PS";
  localparam logic [15:0] CMD_SM = "SM";
  localparam logic [15:0] CMD_TX = "TX";
  localparam logic [15:0] CMD_RX = "RX";
  localparam logic [15:0] CMD_VS = "VS";
  localparam logic [15:0] CMD_RI = "RI";
  localparam logic [15:0] CMD_XT = "XT";
  localparam logic [15:0] CMD_RD = "RD";
  localparam logic [15:0] CMD_RU = "RU";
  localparam logic [15:0] CMD_AG = "AG";
  localparam logic [15:0] CMD_RG = "RG";
  localparam logic [15:0] CMD_SQ = "SQ";
  localparam logic [15:0] CMD_RM = "RM";

  // Flag bit positions.
  localparam int FLAG_POWER = 0;
  localparam int FLAG_PTT   = 1;
  localparam int FLAG_RIT   = 2;
  localparam int FLAG_XIT   = 3;

  localparam logic [2:0] METER_COUNT = 3'd5;

endpackage

// ===== rtl/radio_text_command_interpreter.sv =====
// Top level of the radio text command interpreter.

// Serial bytes enter one beat at a time on the input channel and are upper-cased
// into a 32-entry line memory; control bytes and bytes at or above 128 are dropped,
// and a byte that arrives with 31 bytes held empties the line. A ';' runs the
// two-letter command at the start of the line. A byte that only extends the line,
// and a meter update beat, leave the block idle. A command that sets state from a
// number walks the parameter text one character at a time, each through a
// registered memory read and then a digit step of the accumulator. A reply is sent
// one byte per output beat; each decimal field (IF has two) is first converted by a
// bit-serial double-dabble unit. The input is stalled from the ';' until the last
// reply byte sits in the output register; that byte may wait for the receiver while
// the next input beat is already taken. Configuration writes are taken at any time
// but are meant to happen while the block is idle.
`include "assert_macros.svh"

module radio_text_command_interpreter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [7:0]                         rx_byte_i,
  input  logic [2:0]                         meter_index_i,
  input  logic [7:0]                         meter_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         tx_byte_o,
  output logic                               last_of_reply_o,
  input  logic                               cfg_we_i,
  input  logic [rtci_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rtci_pkg::CFG_W-1:0]         cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SREAD, S_SCHECK, S_SAPPLY, S_EMIT, S_CONV
  } state_e;

  // Reply formats.
  typedef enum logic [2:0] {
    K_FREQ, K_IF, K_ID, K_NUM3, K_MD, K_FLAG, K_RM
  } kind_e;

  // What the reply sequencer does at the current step.
  typedef enum logic [1:0] {
    OP_LIT, OP_CONV, OP_SKIP
  } op_e;

  // Which command a parameter scan serves.
  typedef enum logic [1:0] {
    SC_FREQ, SC_RIT, SC_GAIN
  } scan_e;

  localparam int LW = rtci_pkg::LEN_W;
  localparam int FW = rtci_pkg::FREQ_W;

  state_e                      state_q;
  logic [LW-1:0]               len_q;
  logic [LW-1:0]               exec_len_q;
  logic [7:0]                  line_mem [rtci_pkg::LINE_DEPTH];
  logic [7:0]                  rdata_q;
  logic [7:0]                  head_q [4];

  logic [FW-1:0]               fmin_q, fmax_q;
  logic [rtci_pkg::ID_W-1:0]   id_q;
  logic [FW-1:0]               fa_q, fb_q;
  logic                        vfo_q;
  logic [3:0]                  mode_q [2];
  logic [3:0]                  flags_q;
  logic signed [rtci_pkg::RIT_W-1:0] rit_q;
  logic [7:0]                  gain_q [3];
  logic [7:0]                  meter_q [5];

  kind_e                       kind_q;
  logic [4:0]                  step_q;
  logic                        fbit_q;
  logic [rtci_pkg::ID_W-1:0]   num_q;
  logic                        rm_neg_q;
  logic [3:0]                  rm_tens_q, rm_ones_q;

  scan_e                       scan_kind_q;
  logic [1:0]                  scan_sel_q;
  logic [LW-1:0]               scan_q;
  logic                        sneg_q, spast_q, snd_q, send_q;
  logic [FW-1:0]               mag_q;

  logic [FW-1:0]               conv_q;
  logic [rtci_pkg::BCD_W-1:0]  bcd_q;
  logic [rtci_pkg::CONV_CNT_W-1:0] ccnt_q;

  logic                        out_valid_q, last_q;
  logic [7:0]                  tx_q;

  // ---------------------------------------------------------------------------
  // Input side.
  logic       in_acc;
  logic [7:0] up_byte;
  logic       byte_keep;
  logic       line_full;
  logic       mem_we;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign up_byte    = (rx_byte_i >= rtci_pkg::CH_LOW_A && rx_byte_i <= rtci_pkg::CH_LOW_Z) ?
                      (rx_byte_i - rtci_pkg::CASE_GAP) : rx_byte_i;
  assign byte_keep  = !rx_byte_i[7] && (rx_byte_i >= rtci_pkg::CH_SPACE) &&
                      (rx_byte_i != rtci_pkg::CH_SEMI);
  assign line_full  = (len_q >= LW'(rtci_pkg::LINE_DEPTH - 1));
  assign mem_we     = in_acc && !cmd_i && byte_keep && !line_full;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[len_q] <= up_byte;
    end
    rdata_q <= line_mem[scan_q];
  end

  // ---------------------------------------------------------------------------
  // Command decode helpers.
  logic [7:0]  ca, cb, c2, c3;
  logic [15:0] name;
  logic        plen0, plen_ge1, plen_ge2, plen_le1, plen_ge4;
  logic [3:0]  mode_cur;
  logic [3:0]  md_val;
  logic [7:0]  rm_char;
  logic        rm_neg;
  logic [6:0]  rm_abs;
  logic [3:0]  rm_tens;
  logic [3:0]  rm_ones;
  logic [7:0]  rm_val;

  assign ca   = head_q[0];
  assign cb   = head_q[1];
  assign c2   = head_q[2];
  assign c3   = head_q[3];
  assign name = {ca, cb};

  assign plen0    = (exec_len_q == LW'(2));
  assign plen_ge1 = (exec_len_q >= LW'(3));
  assign plen_ge2 = (exec_len_q >= LW'(4));
  assign plen_le1 = (exec_len_q <= LW'(3));
  assign plen_ge4 = (exec_len_q >= LW'(6));

  assign mode_cur = mode_q[vfo_q];

  always_comb begin
    md_val = 4'd0;
    if (c3 >= rtci_pkg::CH_ONE && c3 <= rtci_pkg::CH_NINE) begin
      md_val = c3[3:0];
    end else if (c3 >= rtci_pkg::CH_A && c3 <= rtci_pkg::CH_E) begin
      md_val = 4'(c3 - rtci_pkg::CH_A + 8'd10);
    end
  end

  // Meter number of RM: one character minus '0', which can be negative.
  always_comb begin
    rm_char = plen_ge1 ? c2 : rtci_pkg::CH_ONE;
    rm_neg  = (rm_char < rtci_pkg::CH_ZERO);
    rm_abs  = rm_neg ? 7'(rtci_pkg::CH_ZERO - rm_char) : 7'(rm_char - rtci_pkg::CH_ZERO);
    rm_tens = 4'd0;
    for (int k = 1; k <= 7; k++) begin
      if (rm_abs >= 7'(10 * k)) rm_tens = 4'(k);
    end
    rm_ones = 4'(rm_abs - 7'(rm_tens * 4'd10));
    rm_val  = (!rm_neg && rm_abs >= 7'd1 && rm_abs <= 7'd5) ? meter_q[3'(rm_abs - 7'd1)] : 8'd0;
  end

  // RIT up/down by one step, clamped.
  logic signed [rtci_pkg::RIT_W:0]   rit_sum;
  logic signed [rtci_pkg::RIT_W-1:0] rit_stepped;

  assign rit_sum = {rit_q[rtci_pkg::RIT_W-1], rit_q} +
                   ((cb == rtci_pkg::CMD_RU[7:0]) ? rtci_pkg::RIT_STEP : -rtci_pkg::RIT_STEP);
  always_comb begin
    if (rit_sum > 16'(rtci_pkg::RIT_LIMIT))        rit_stepped = rtci_pkg::RIT_LIMIT;
    else if (rit_sum < -16'(rtci_pkg::RIT_LIMIT))  rit_stepped = -rtci_pkg::RIT_LIMIT;
    else                                           rit_stepped = rit_sum[rtci_pkg::RIT_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Parameter scan: one character per step into a saturating accumulator.
  logic        ch_digit;
  logic [33:0] mag_x10;
  logic [33:0] sat_lim;
  logic [FW-1:0] mag_next;

  assign ch_digit = (rdata_q >= rtci_pkg::CH_ZERO) && (rdata_q <= rtci_pkg::CH_NINE);
  assign mag_x10  = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + {30'd0, rdata_q[3:0]};
  assign sat_lim  = (scan_kind_q == SC_FREQ) ? rtci_pkg::FREQ_SAT : rtci_pkg::LENIENT_SAT;
  assign mag_next = (mag_x10 > sat_lim) ? sat_lim[FW-1:0] : mag_x10[FW-1:0];

  logic        freq_ok;
  logic [13:0] rit_mag;
  logic signed [rtci_pkg::RIT_W-1:0] rit_parsed;
  logic [7:0]  gain_top;
  logic [7:0]  gain_parsed;

  assign freq_ok = snd_q && send_q && !(sneg_q && (mag_q != '0)) &&
                   (mag_q <= rtci_pkg::FREQ_TOP) && (mag_q >= fmin_q) && (mag_q <= fmax_q);
  assign rit_mag = (mag_q > FW'(rtci_pkg::RIT_MAG_TOP)) ? rtci_pkg::RIT_MAG_TOP : mag_q[13:0];
  assign rit_parsed = sneg_q ? -$signed({1'b0, rit_mag}) : $signed({1'b0, rit_mag});
  assign gain_top = (scan_sel_q == 2'd2) ? rtci_pkg::SQL_TOP : rtci_pkg::GAIN_TOP;
  assign gain_parsed = sneg_q ? 8'd0 : ((mag_q > FW'(gain_top)) ? gain_top : mag_q[7:0]);

  // ---------------------------------------------------------------------------
  // Reply sequencer: what happens at each step of each reply format.
  function automatic logic [7:0] dchar(input logic [rtci_pkg::BCD_W-1:0] bcd,
                                       input logic [3:0] k);
    dchar = rtci_pkg::CH_ZERO | {4'h0, bcd[{k, 2'b00} +: 4]};
  endfunction

  logic        off_neg;
  logic [13:0] off_abs;
  logic [7:0]  mode_hex;
  logic        mode_big;

  assign off_neg  = flags_q[rtci_pkg::FLAG_RIT] && rit_q[rtci_pkg::RIT_W-1];
  assign off_abs  = !flags_q[rtci_pkg::FLAG_RIT] ? 14'd0 :
                    (off_neg ? 14'(-rit_q) : rit_q[13:0]);
  assign mode_big = (mode_cur >= 4'd10);
  assign mode_hex = mode_big ? (rtci_pkg::CH_A + {4'h0, mode_cur - 4'd10}) :
                               (rtci_pkg::CH_ZERO + {4'h0, mode_cur});

  op_e           it_op;
  logic [7:0]    it_byte;
  logic          it_last;
  logic [FW-1:0] it_conv;

  always_comb begin
    it_op   = OP_LIT;
    it_byte = rtci_pkg::CH_ZERO;
    it_last = 1'b0;
    it_conv = '0;
    unique case (kind_q)
      K_FREQ: begin
        priority if (step_q == 5'd0) begin
          it_op   = OP_CONV;
          it_conv = (cb == rtci_pkg::CH_B) ? fb_q : fa_q;
        end else if (step_q == 5'd1) it_byte = ca;
        else if (step_q == 5'd2)     it_byte = cb;
        else if (step_q <= 5'd11)    it_byte = dchar(bcd_q, 4'(5'd11 - step_q));
        else begin
          it_byte = rtci_pkg::CH_SEMI;
          it_last = 1'b1;
        end
      end
      K_IF: begin
        priority if (step_q == 5'd0) begin
          it_op   = OP_CONV;
          it_conv = vfo_q ? fb_q : fa_q;
        end else if (step_q == 5'd1) it_byte = rtci_pkg::CH_I;
        else if (step_q == 5'd2)     it_byte = rtci_pkg::CH_F;
        else if (step_q <= 5'd11)    it_byte = dchar(bcd_q, 4'(5'd11 - step_q));
        else if (step_q == 5'd12) begin
          it_op   = OP_CONV;
          it_conv = FW'(off_abs);
        end else if (step_q == 5'd13) it_byte = off_neg ? rtci_pkg::CH_MINUS : rtci_pkg::CH_PLUS;
        else if (step_q <= 5'd17)     it_byte = dchar(bcd_q, 4'(5'd17 - step_q));
        else if (step_q == 5'd18)     it_byte = rtci_pkg::CH_ZERO;
        else if (step_q == 5'd19)     it_byte = mode_big ? rtci_pkg::CH_ONE : rtci_pkg::CH_ZERO;
        else if (step_q == 5'd20)     it_byte = rtci_pkg::CH_ZERO +
                                                {4'h0, mode_big ? mode_cur - 4'd10 : mode_cur};
        else if (step_q <= 5'd30)     it_byte = rtci_pkg::CH_ZERO;
        else begin
          it_byte = rtci_pkg::CH_SEMI;
          it_last = 1'b1;
        end
      end
      K_ID: begin
        priority if (step_q == 5'd0) begin
          it_op   = OP_CONV;
          it_conv = FW'(num_q);
        end else if (step_q == 5'd1) it_byte = ca;
        else if (step_q == 5'd2)     it_byte = cb;
        else if (step_q <= 5'd6)     it_byte = dchar(bcd_q, 4'(5'd6 - step_q));
        else begin
          it_byte = rtci_pkg::CH_SEMI;
          it_last = 1'b1;
        end
      end
      K_NUM3: begin
        priority if (step_q == 5'd0) begin
          it_op   = OP_CONV;
          it_conv = FW'(num_q);
        end else if (step_q == 5'd1) it_byte = ca;
        else if (step_q == 5'd2)     it_byte = cb;
        else if (step_q == 5'd3)     it_byte = rtci_pkg::CH_ZERO;
        else if (step_q <= 5'd6)     it_byte = dchar(bcd_q, 4'(5'd6 - step_q));
        else begin
          it_byte = rtci_pkg::CH_SEMI;
          it_last = 1'b1;
        end
      end
      K_MD: begin
        priority if (step_q == 5'd0) it_byte = ca;
        else if (step_q == 5'd1)     it_byte = cb;
        else if (step_q == 5'd2)     it_byte = rtci_pkg::CH_ZERO;
        else if (step_q == 5'd3)     it_byte = mode_hex;
        else begin
          it_byte = rtci_pkg::CH_SEMI;
          it_last = 1'b1;
        end
      end
      K_FLAG: begin
        priority if (step_q == 5'd0) it_byte = ca;
        else if (step_q == 5'd1)     it_byte = cb;
        else if (step_q == 5'd2)     it_byte = rtci_pkg::CH_ZERO | {7'd0, fbit_q};
        else begin
          it_byte = rtci_pkg::CH_SEMI;
          it_last = 1'b1;
        end
      end
      K_RM: begin
        priority if (step_q == 5'd0) begin
          it_op   = OP_CONV;
          it_conv = FW'(num_q);
        end else if (step_q == 5'd1) it_byte = ca;
        else if (step_q == 5'd2)     it_byte = cb;
        else if (step_q == 5'd3) begin
          it_op   = rm_neg_q ? OP_LIT : OP_SKIP;
          it_byte = rtci_pkg::CH_MINUS;
        end else if (step_q == 5'd4) begin
          it_op   = (rm_tens_q != 4'd0) ? OP_LIT : OP_SKIP;
          it_byte = rtci_pkg::CH_ZERO | {4'h0, rm_tens_q};
        end else if (step_q == 5'd5) it_byte = rtci_pkg::CH_ZERO | {4'h0, rm_ones_q};
        else if (step_q <= 5'd8)     it_byte = dchar(bcd_q, 4'(5'd8 - step_q));
        else begin
          it_byte = rtci_pkg::CH_SEMI;
          it_last = 1'b1;
        end
      end
      default: begin
        it_op = OP_SKIP;
      end
    endcase
  end

  // Double dabble: add three to each BCD digit of five or more, then shift.
  logic [rtci_pkg::BCD_W-1:0] bcd_adj;

  always_comb begin
    for (int d = 0; d < rtci_pkg::BCD_W / 4; d++) begin
      bcd_adj[d*4 +: 4] = (bcd_q[d*4 +: 4] >= 4'd5) ? (bcd_q[d*4 +: 4] + 4'd3) : bcd_q[d*4 +: 4];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      exec_len_q  <= '0;
      for (int i = 0; i < 4; i++) head_q[i] <= '0;
      fmin_q      <= rtci_pkg::FREQ_MIN_RST;
      fmax_q      <= rtci_pkg::FREQ_MAX_RST;
      id_q        <= rtci_pkg::RADIO_ID_RST;
      fa_q        <= '0;
      fb_q        <= '0;
      vfo_q       <= 1'b0;
      mode_q[0]   <= 4'd1;
      mode_q[1]   <= 4'd1;
      flags_q     <= '0;
      rit_q       <= '0;
      for (int i = 0; i < 3; i++) gain_q[i] <= '0;
      for (int i = 0; i < 5; i++) meter_q[i] <= '0;
      kind_q      <= K_FLAG;
      step_q      <= '0;
      fbit_q      <= 1'b0;
      num_q       <= '0;
      rm_neg_q    <= 1'b0;
      rm_tens_q   <= '0;
      rm_ones_q   <= '0;
      scan_kind_q <= SC_FREQ;
      scan_sel_q  <= '0;
      scan_q      <= '0;
      sneg_q      <= 1'b0;
      spast_q     <= 1'b0;
      snd_q       <= 1'b0;
      send_q      <= 1'b0;
      mag_q       <= '0;
      conv_q      <= '0;
      bcd_q       <= '0;
      ccnt_q      <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      tx_q        <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rtci_pkg::CFG_FREQ_MIN: fmin_q <= cfg_data_i[FW-1:0];
          rtci_pkg::CFG_FREQ_MAX: fmax_q <= cfg_data_i[FW-1:0];
          rtci_pkg::CFG_RADIO_ID: id_q   <= cfg_data_i[rtci_pkg::ID_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (cmd_i) begin
              if (meter_index_i < rtci_pkg::METER_COUNT) begin
                meter_q[meter_index_i] <= meter_value_i;
              end
            end else if (rx_byte_i == rtci_pkg::CH_SEMI) begin
              // A line of one byte runs nothing.
              if (len_q >= LW'(2)) begin
                exec_len_q <= len_q;
                state_q    <= S_DECODE;
              end
              len_q <= '0;
            end else if (byte_keep) begin
              if (line_full) begin
                len_q <= '0;
              end else begin
                if (len_q < LW'(4)) head_q[len_q[1:0]] <= up_byte;
                len_q <= len_q + LW'(1);
              end
            end
          end
        end

        S_DECODE: begin
          state_q     <= S_IDLE;
          step_q      <= '0;
          scan_q      <= LW'(2);
          sneg_q      <= 1'b0;
          spast_q     <= 1'b0;
          snd_q       <= 1'b0;
          send_q      <= 1'b0;
          mag_q       <= '0;
          unique case (name)
            rtci_pkg::CMD_FA, rtci_pkg::CMD_FB: begin
              if (plen0) begin
                kind_q  <= K_FREQ;
                state_q <= S_EMIT;
              end else begin
                scan_kind_q <= SC_FREQ;
                scan_sel_q  <= {1'b0, cb == rtci_pkg::CH_B};
                state_q     <= S_SREAD;
              end
            end
            rtci_pkg::CMD_IF: begin
              kind_q  <= K_IF;
              state_q <= S_EMIT;
            end
            rtci_pkg::CMD_ID: begin
              num_q   <= (id_q > rtci_pkg::ID_TOP) ? rtci_pkg::ID_TOP : id_q;
              kind_q  <= K_ID;
              state_q <= S_EMIT;
            end
            rtci_pkg::CMD_MD: begin
              if (plen0) begin
                kind_q  <= K_MD;
                state_q <= S_EMIT;
              end else if (plen_ge2 && md_val != 4'd0) begin
                mode_q[vfo_q] <= md_val;
              end
            end
            rtci_pkg::CMD_PS, rtci_pkg::CMD_RI, rtci_pkg::CMD_XT: begin
              if (plen0) begin
                fbit_q  <= (name == rtci_pkg::CMD_PS) ? flags_q[rtci_pkg::FLAG_POWER] :
                           (name == rtci_pkg::CMD_RI) ? flags_q[rtci_pkg::FLAG_RIT] :
                                                        flags_q[rtci_pkg::FLAG_XIT];
                kind_q  <= K_FLAG;
                state_q <= S_EMIT;
              end else if (name == rtci_pkg::CMD_PS) begin
                flags_q[rtci_pkg::FLAG_POWER] <= (c2 == rtci_pkg::CH_ONE);
              end else if (name == rtci_pkg::CMD_RI) begin
                flags_q[rtci_pkg::FLAG_RIT] <= (c2 == rtci_pkg::CH_ONE);
              end else begin
                flags_q[rtci_pkg::FLAG_XIT] <= (c2 == rtci_pkg::CH_ONE);
              end
            end
            rtci_pkg::CMD_TX: begin
              if (plen0) begin
                fbit_q  <= flags_q[rtci_pkg::FLAG_PTT];
                kind_q  <= K_FLAG;
                state_q <= S_EMIT;
              end else begin
                flags_q[rtci_pkg::FLAG_PTT] <= (c2 != rtci_pkg::CH_ZERO);
              end
            end
            rtci_pkg::CMD_RX: begin
              flags_q[rtci_pkg::FLAG_PTT] <= 1'b0;
            end
            rtci_pkg::CMD_VS: begin
              if (plen0) begin
                fbit_q  <= vfo_q;
                kind_q  <= K_FLAG;
                state_q <= S_EMIT;
              end else begin
                vfo_q <= (c2 != rtci_pkg::CH_ZERO);
              end
            end
            rtci_pkg::CMD_SM: begin
              num_q   <= rtci_pkg::ID_W'(meter_q[0]);
              kind_q  <= K_NUM3;
              state_q <= S_EMIT;
            end
            rtci_pkg::CMD_RD, rtci_pkg::CMD_RU: begin
              if (plen_ge4) begin
                scan_kind_q <= SC_RIT;
                state_q     <= S_SREAD;
              end else begin
                rit_q <= rit_stepped;
              end
            end
            rtci_pkg::CMD_AG, rtci_pkg::CMD_RG, rtci_pkg::CMD_SQ: begin
              // Gain index: audio, rf, squelch.
              if (plen_le1) begin
                num_q   <= rtci_pkg::ID_W'(gain_q[(name == rtci_pkg::CMD_AG) ? 0 :
                                                  (name == rtci_pkg::CMD_RG) ? 1 : 2]);
                kind_q  <= K_NUM3;
                state_q <= S_EMIT;
              end else if (plen_ge4) begin
                scan_kind_q <= SC_GAIN;
                scan_sel_q  <= (name == rtci_pkg::CMD_AG) ? 2'd0 :
                               (name == rtci_pkg::CMD_RG) ? 2'd1 : 2'd2;
                scan_q      <= LW'(3);
                state_q     <= S_SREAD;
              end
            end
            rtci_pkg::CMD_RM: begin
              num_q     <= rtci_pkg::ID_W'(rm_val);
              rm_neg_q  <= rm_neg;
              rm_tens_q <= rm_tens;
              rm_ones_q <= rm_ones;
              kind_q    <= K_RM;
              state_q   <= S_EMIT;
            end
            default: ;
          endcase
        end

        // The memory read of the current character is issued here.
        S_SREAD: begin
          if (scan_q == exec_len_q) begin
            send_q  <= 1'b1;
            state_q <= S_SAPPLY;
          end else begin
            state_q <= S_SCHECK;
          end
        end

        // Leading spaces, then one optional sign, then digits.
        S_SCHECK: begin
          priority if (!spast_q && rdata_q == rtci_pkg::CH_SPACE) begin
            scan_q  <= scan_q + LW'(1);
            state_q <= S_SREAD;
          end else if (!spast_q &&
                       (rdata_q == rtci_pkg::CH_PLUS || rdata_q == rtci_pkg::CH_MINUS)) begin
            sneg_q  <= (rdata_q == rtci_pkg::CH_MINUS);
            spast_q <= 1'b1;
            scan_q  <= scan_q + LW'(1);
            state_q <= S_SREAD;
          end else if (ch_digit) begin
            mag_q   <= mag_next;
            snd_q   <= 1'b1;
            spast_q <= 1'b1;
            scan_q  <= scan_q + LW'(1);
            state_q <= S_SREAD;
          end else begin
            state_q <= S_SAPPLY;
          end
        end

        S_SAPPLY: begin
          state_q <= S_IDLE;
          unique case (scan_kind_q)
            SC_FREQ: begin
              if (freq_ok) begin
                if (scan_sel_q[0]) fb_q <= mag_q;
                else               fa_q <= mag_q;
              end
            end
            SC_RIT:  rit_q <= rit_parsed;
            SC_GAIN: gain_q[scan_sel_q] <= gain_parsed;
            default: ;
          endcase
        end

        S_EMIT: begin
          unique case (it_op)
            OP_CONV: begin
              conv_q  <= it_conv;
              bcd_q   <= '0;
              ccnt_q  <= '0;
              step_q  <= step_q + 5'd1;
              state_q <= S_CONV;
            end
            OP_SKIP: begin
              step_q <= step_q + 5'd1;
            end
            OP_LIT: begin
              if (out_free) begin
                out_valid_q <= 1'b1;
                tx_q        <= it_byte;
                last_q      <= it_last;
                step_q      <= step_q + 5'd1;
                if (it_last) state_q <= S_IDLE;
              end
            end
            default: ;
          endcase
        end

        S_CONV: begin
          bcd_q  <= {bcd_adj[rtci_pkg::BCD_W-2:0], conv_q[FW-1]};
          conv_q <= {conv_q[FW-2:0], 1'b0};
          ccnt_q <= ccnt_q + rtci_pkg::CONV_CNT_W'(1);
          if (ccnt_q == rtci_pkg::CONV_CNT_W'(FW - 1)) state_q <= S_EMIT;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tx_byte_o       = tx_q;
  assign last_of_reply_o = last_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  logic overflow_beat;
  assign overflow_beat = in_acc && !cmd_i && byte_keep && line_full;

  `RTCI_ASSERT(a_overflow_empties, overflow_beat |=> (len_q == '0), "overflow kept the line")
  `RTCI_ASSERT(a_last_is_semi, (out_valid_o && last_of_reply_o) |-> (tx_byte_o == rtci_pkg::CH_SEMI), "last byte is not a semicolon")
  `RTCI_ASSERT_ALWAYS(a_rit_range, (rit_q <= rtci_pkg::RIT_LIMIT) && (rit_q >= -rtci_pkg::RIT_LIMIT), "RIT offset out of range")
  `RTCI_ASSERT(a_conv_stalls_in, (state_q == S_CONV) |=> in_stall_o, "input taken during conversion")

endmodule

// ===== test/radio_text_command_interpreter_tb.sv =====
// Testbench for the radio text command interpreter: byte and meter stimulus with reply checking.
module radio_text_command_interpreter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtci_pkg::*;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic [2:0] meter_index;
    logic [7:0] meter_value;
  } beat_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = 1'b0;
  logic [7:0] rx_byte_i = '0;
  logic [2:0] meter_index_i = '0;
  logic [7:0] meter_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] tx_byte_o;
  logic last_of_reply_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  radio_text_command_interpreter dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the interpreter's state.
  logic [FREQ_W-1:0] lo_freq, hi_freq, vfo_a, vfo_b;
  logic [ID_W-1:0] id_num;
  logic [7:0] line [LINE_DEPTH];
  int line_len;
  logic vfo_b_sel;
  logic [3:0] vfo_mode [2];
  logic [3:0] flags;
  int rit;
  int gains [3];
  logic [7:0] meters [5];

  beat_t pending[$];
  reply_t replies_due[$];
  int fail_count = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  task automatic emit(input logic [7:0] b, input logic l = 1'b0);
    replies_due.push_back('{b, l});
  endtask

  task automatic emit_dec(input longint v, input int digits);
    logic [7:0] d [10];
    for (int i = digits - 1; i >= 0; i--) begin
      d[i] = 8'(CH_ZERO + v % 10);
      v = v / 10;
    end
    for (int i = 0; i < digits; i++) emit(d[i]);
  endtask

  function automatic bit is_num(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Forgiving number: spaces, sign, leading digits; magnitude saturates.
  function automatic int loose_number(input int pos);
    int i;
    bit neg;
    int mag;
    i = pos;
    neg = 0;
    mag = 0;
    while (i < line_len && line[i] == CH_SPACE) i++;
    if (i < line_len && (line[i] == CH_PLUS || line[i] == CH_MINUS)) begin
      neg = line[i] == CH_MINUS;
      i++;
    end
    while (i < line_len && is_num(line[i])) begin
      mag = mag * 10 + (line[i] - CH_ZERO);
      if (mag > 100000) mag = 100000;
      i++;
    end
    return neg ? -mag : mag;
  endfunction

  function automatic bit freq_text(output logic [FREQ_W-1:0] f);
    int i, nd;
    bit neg;
    longint mag;
    i = 2;
    nd = 0;
    neg = 0;
    mag = 0;
    f = '0;
    while (i < line_len && line[i] == CH_SPACE) i++;
    if (i < line_len && (line[i] == CH_PLUS || line[i] == CH_MINUS)) begin
      neg = line[i] == CH_MINUS;
      i++;
    end
    while (i < line_len && is_num(line[i])) begin
      mag = mag * 10 + (line[i] - CH_ZERO);
      if (mag > 1000000000) mag = 1000000000;
      nd++;
      i++;
    end
    if (nd == 0 || i != line_len) return 0;
    if (neg && mag != 0) return 0;
    if (mag > 999999999 || mag < lo_freq || mag > hi_freq) return 0;
    f = FREQ_W'(mag);
    return 1;
  endfunction

  function automatic int clip(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic flag_reply(input logic [15:0] nm, input int bit_pos, input int plen);
    if (plen == 0) begin
      emit(nm[15:8]); emit(nm[7:0]);
      emit(8'(CH_ZERO + flags[bit_pos]));
      emit(CH_SEMI, 1'b1);
    end else flags[bit_pos] = line[2] == CH_ONE;
  endtask

  task automatic gain_reply(input logic [15:0] nm, input int idx, input int top, input int plen);
    if (plen <= 1) begin
      emit(nm[15:8]); emit(nm[7:0]); emit(CH_ZERO);
      emit_dec(gains[idx], 3);
      emit(CH_SEMI, 1'b1);
    end else if (plen >= 4) gains[idx] = clip(loose_number(3), 0, top);
  endtask

  task automatic run_command();
    int plen, off, num;
    logic [15:0] nm;
    logic [3:0] m;
    logic [FREQ_W-1:0] f;
    logic [7:0] c;
    int v;
    if (line_len < 2) return;
    plen = line_len - 2;
    nm = {line[0], line[1]};
    m = vfo_mode[vfo_b_sel];
    case (nm)
      CMD_FA, CMD_FB: begin
        if (plen == 0) begin
          emit(nm[15:8]); emit(nm[7:0]);
          emit_dec(nm == CMD_FA ? vfo_a : vfo_b, 9);
          emit(CH_SEMI, 1'b1);
        end else if (freq_text(f)) begin
          if (nm == CMD_FA) vfo_a = f; else vfo_b = f;
        end
      end
      CMD_IF: begin
        off = flags[FLAG_RIT] ? rit : 0;
        emit(nm[15:8]); emit(nm[7:0]);
        emit_dec(vfo_b_sel ? vfo_b : vfo_a, 9);
        emit(off < 0 ? CH_MINUS : CH_PLUS);
        emit_dec(off < 0 ? -off : off, 4);
        emit(CH_ZERO);
        emit_dec(m, 2);
        emit_dec(0, 10);
        emit(CH_SEMI, 1'b1);
      end
      CMD_ID: begin
        emit(nm[15:8]); emit(nm[7:0]);
        emit_dec(id_num > ID_TOP ? ID_TOP : id_num, 4);
        emit(CH_SEMI, 1'b1);
      end
      CMD_MD: begin
        if (plen == 0) begin
          emit(nm[15:8]); emit(nm[7:0]); emit(CH_ZERO);
          emit(m < 10 ? 8'(CH_ZERO + m) : 8'(CH_A + m - 10));
          emit(CH_SEMI, 1'b1);
        end else if (plen >= 2) begin
          c = line[3];
          v = 0;
          if (c >= CH_ONE && c <= CH_NINE) v = c - CH_ZERO;
          else if (c >= CH_A && c <= CH_E) v = c - CH_A + 10;
          if (v != 0) vfo_mode[vfo_b_sel] = 4'(v);
        end
      end
      CMD_PS: flag_reply(nm, FLAG_POWER, plen);
      CMD_SM: begin
        emit(nm[15:8]); emit(nm[7:0]); emit(CH_ZERO);
        emit_dec(meters[0], 3);
        emit(CH_SEMI, 1'b1);
      end
      CMD_TX: begin
        if (plen == 0) begin
          emit(nm[15:8]); emit(nm[7:0]);
          emit(8'(CH_ZERO + flags[FLAG_PTT]));
          emit(CH_SEMI, 1'b1);
        end else flags[FLAG_PTT] = line[2] != CH_ZERO;
      end
      CMD_RX: flags[FLAG_PTT] = 1'b0;
      CMD_VS: begin
        if (plen == 0) begin
          emit(nm[15:8]); emit(nm[7:0]);
          emit(8'(CH_ZERO + vfo_b_sel));
          emit(CH_SEMI, 1'b1);
        end else vfo_b_sel = line[2] != CH_ZERO;
      end
      CMD_RI: flag_reply(nm, FLAG_RIT, plen);
      CMD_XT: flag_reply(nm, FLAG_XIT, plen);
      CMD_RD, CMD_RU: begin
        if (plen >= 4) rit = clip(loose_number(2), -9999, 9999);
        else rit = clip(rit + (nm == CMD_RD ? -10 : 10), -9999, 9999);
      end
      CMD_AG: gain_reply(nm, 0, 255, plen);
      CMD_RG: gain_reply(nm, 1, 255, plen);
      CMD_SQ: gain_reply(nm, 2, 100, plen);
      CMD_RM: begin
        num = plen >= 1 ? int'(line[2]) - int'(CH_ZERO) : 1;
        v = (num >= 1 && num <= 5) ? meters[num - 1] : 0;
        emit(nm[15:8]); emit(nm[7:0]);
        if (num < 0) begin
          emit(CH_MINUS);
          num = -num;
        end
        emit_dec(num, num >= 10 ? 2 : 1);
        emit_dec(v, 3);
        emit(CH_SEMI, 1'b1);
      end
      default: ;
    endcase
  endtask

  // Works out the replies that one accepted input beat causes.
  task automatic predict_beat(input beat_t b);
    logic [7:0] c;
    if (b.cmd) begin
      if (b.meter_index < METER_COUNT) meters[b.meter_index] = b.meter_value;
      return;
    end
    c = b.rx_byte;
    if (c == CH_SEMI) begin
      if (line_len > 0) run_command();
      line_len = 0;
    end else if (c >= 8'd32 && c < 8'd128) begin
      if (line_len < LINE_DEPTH - 1) begin
        if (c >= CH_LOW_A && c <= CH_LOW_Z) c = c - CASE_GAP;
        line[line_len] = c;
        line_len++;
      end else line_len = 0;
    end
  endtask

  task automatic shadow_reset();
    lo_freq = FREQ_MIN_RST;
    hi_freq = FREQ_MAX_RST;
    id_num = RADIO_ID_RST;
    line_len = 0;
    vfo_a = '0;
    vfo_b = '0;
    vfo_b_sel = 1'b0;
    vfo_mode[0] = 4'd1;
    vfo_mode[1] = 4'd1;
    flags = '0;
    rit = 0;
    for (int i = 0; i < 3; i++) gains[i] = 0;
    for (int i = 0; i < 5; i++) meters[i] = '0;
  endtask

  // Driver: one beat at a time from the pending queue, with random gap bursts.
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_beat({cmd_i, rx_byte_i, meter_index_i,
                                                   meter_value_i});
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending.size() > 0 && !hold_off) begin
          {cmd_i, rx_byte_i, meter_index_i, meter_value_i} <= pending.pop_front();
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 11);
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks reply bytes and drives random stall bursts.
  int out_gap = 0;
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          $error("unexpected reply byte tx_byte=%0h", tx_byte_o);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (want.tx_byte !== tx_byte_o) begin
            $error("tx_byte expected %0h actual %0h", want.tx_byte, tx_byte_o);
            fail_count++;
          end
          if (want.last !== last_of_reply_o) begin
            $error("last_of_reply expected %0b actual %0b", want.last, last_of_reply_o);
            fail_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else out_stall_i <= 1'b0;
    end
  end

  // Watchdog: cycles with no beat accepted on either side.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[radio_text_command_interpreter] ERROR");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] c);
    pending.push_back('{1'b0, c, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_meter(input logic [2:0] idx, input logic [7:0] val);
    pending.push_back('{1'b1, 8'($urandom_range(0, 255)), idx, val});
  endtask

  // Waits for the driver to drain and all replies to arrive, then for trailing work.
  task automatic settle();
    wait (pending.size() == 0 && !in_valid_i && replies_due.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FREQ_MIN: lo_freq = val;
      CFG_FREQ_MAX: hi_freq = val;
      CFG_RADIO_ID: id_num = val[ID_W-1:0];
      default: ;
    endcase
  endtask

  string names [18] = '{"FA", "FB", "IF", "ID", "MD", "PS", "SM", "TX", "RX", "VS",
                        "RI", "XT", "RD", "RU", "AG", "RG", "SQ", "RM"};

  function automatic string rand_digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    return s;
  endfunction

  // A well-formed command with random parameter text, ending in ';'.
  task automatic add_command();
    string s, p;
    int k;
    s = names[$urandom_range(0, 17)];
    if ($urandom_range(0, 1)) s = s.tolower();
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2: p = "";
      3: p = rand_digits($urandom_range(1, 11));
      4: p = {($urandom_range(0, 1) ? "-" : "+"), rand_digits($urandom_range(1, 6))};
      5: p = {" ", rand_digits($urandom_range(3, 9))};
      6: p = string'(8'($urandom_range(32, 126)));
      7: p = {"0", string'(8'($urandom_range(32, 126)))};
      8: p = {rand_digits(1), "X", rand_digits(2)};
      default: p = {rand_digits($urandom_range(4, 9)), "a"};
    endcase
    add_text({s, p, ";"});
  endtask

  initial begin
    shadow_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: queries at reset, sets, clamps, dropped bytes and overflow.
    add_text("ID;IF;fa;FA14074000;FA;FA-0;md;MD0c;MD;ps1;PS;rit;RD-99999;RI1;IF;");
    add_byte(8'h00); add_byte(8'hFF); add_byte(8'h80); add_byte(8'h1F);
    add_text("AG 99999;AG;SQ0500;SQ;RM;RM/;RM9;");
    add_meter(3'd0, 8'hFF); add_meter(3'd7, 8'h55); add_meter(3'd4, 8'hAA);
    add_text("SM;RM5;Q;;ZZ;");
    for (int i = 0; i < LINE_DEPTH + 2; i++) add_byte(CH_A);
    add_text("vs1;FB;VS;tx;TX;RX;TX;xt1;XT;RU;");
    settle();

    // Extreme register settings.
    write_reg(CFG_FREQ_MIN, '0);
    write_reg(CFG_FREQ_MAX, 30'h3FFFFFFF);
    write_reg(CFG_RADIO_ID, 30'h3FFF);
    add_text("ID;FA0;FA;FB999999999;FB;FB1000000000;FB;");
    settle();

    // Queue an IF query with hold_off set and cleared at once, so the sender is not paused.
    hold_off = 1'b1;
    add_text("IF;");
    hold_off = 1'b0;
    settle();

    write_reg(CFG_FREQ_MIN, 30'd999999999);
    write_reg(CFG_FREQ_MAX, 30'd999999999);
    write_reg(CFG_RADIO_ID, 30'd0);
    add_text("ID;FA999999999;FA;FA999999998;FA;");
    settle();

    write_reg(CFG_FREQ_MIN, 30'($urandom_range(0, 5000000)));
    write_reg(CFG_FREQ_MAX, 30'($urandom_range(5000000, 999999999)));
    write_reg(CFG_RADIO_ID, 30'($urandom_range(0, 9999)));

    // Random part: mostly complete commands, some noise and meter updates.
    for (int n = 0; n < 60; n++) begin
      if (n == 48) begin
        settle();
        quiet = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: add_byte(8'($urandom_range(0, 255)));
        1: add_meter(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        default: add_command();
      endcase
    end
    settle();

    if (fail_count == 0) $display("[radio_text_command_interpreter] OK");
    else $display("[radio_text_command_interpreter] ERROR");
    $finish;
  end
endmodule
